/* rtl/core/ost_pkg.sv */
// Shared types, codes and defaults for the ordered sequence table.
package ost_pkg;

    localparam int OST_DEPTH       = 64;
    localparam int OST_VALUE_WIDTH = 32;

    localparam logic [6:0] CAP_RESET         = 7'd64;
    localparam logic [1:0] REG_CAPACITY_ADDR = 2'd0;

    typedef enum logic [2:0] {
        OP_INSERT_AT     = 3'd0,
        OP_INSERT_SORTED = 3'd1,
        OP_ERASE_AT      = 3'd2,
        OP_REMOVE_ALL    = 3'd3,
        OP_FIND          = 3'd4,
        OP_GET           = 3'd5,
        OP_SET           = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_RANGE     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic eq;
        logic ge;
    } t_cmp;

endpackage

/* rtl/core/ordered_sequence_table_core.sv */
// Top level of the ordered sequence table: a packed list in RAM with a count.
// Set, refused items and scans of an empty list go straight to the result strobe;
// get passes through a RAM read state first; shifts, scans and compaction step
// through the list one RAM entry a cycle, and a sorted insert scans, then shifts.
// A new item is taken from the cycle after the strobe; the receiver cannot stall.
// Synchronous reset empties the list and sets capacity to 64; entries are not cleared.
module ordered_sequence_table_core
    import ost_pkg::*;
#(
    parameter int DEPTH       = OST_DEPTH,
    parameter int VALUE_WIDTH = OST_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [6:0]  i_position,
    input  logic [31:0] i_item_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [5:0]  o_result_index,
    output logic [6:0]  o_removed_count,
    output logic [31:0] o_read_value,
    output logic [6:0]  o_list_size,
    output logic        o_is_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [6:0]             capacity;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic [VALUE_WIDTH-1:0] key;
    t_cmp                   cmp_res;
    t_status                status;

    ost_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    ost_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ost_cmp #(
        .WIDTH (VALUE_WIDTH)
    ) u_cmp (
        .i_entry (ram_rdata),
        .i_key   (key),
        .o_res   (cmp_res)
    );

    ost_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_operation     (i_operation),
        .i_position      (i_position),
        .i_item_value    (i_item_value),
        .i_capacity      (capacity),
        .o_busy          (busy),
        .o_done          (o_done),
        .o_status        (status),
        .o_result_index  (o_result_index),
        .o_removed_count (o_removed_count),
        .o_read_value    (o_read_value),
        .o_list_size     (o_list_size),
        .o_is_empty      (o_is_empty),
        .o_we            (ram_we),
        .o_waddr         (ram_waddr),
        .o_wdata         (ram_wdata),
        .o_re            (ram_re),
        .o_raddr         (ram_raddr),
        .i_rdata         (ram_rdata),
        .o_key           (key),
        .i_cmp           (cmp_res)
    );

    assign o_status = status;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted beat did not make the block busy.");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("Result strobe lasted more than one cycle.");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("Result strobe while the block reports idle.");

    a_fail_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STAT_OK)) |-> (o_removed_count == 7'd0))
        else $error("Refused beat reports removed entries.");
`endif

endmodule

/* rtl/core/ost_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ost_ram
    import ost_pkg::*;
#(
    parameter int WIDTH = OST_VALUE_WIDTH,
    parameter int DEPTH = OST_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ost_cmp.sv */
// Shared magnitude and equality comparator for stored entries against the key.
module ost_cmp
    import ost_pkg::*;
#(
    parameter int WIDTH = OST_VALUE_WIDTH
) (
    input  logic [WIDTH-1:0] i_entry,
    input  logic [WIDTH-1:0] i_key,
    output t_cmp             o_res
);

    always_comb begin
        o_res.eq = (i_entry == i_key);
        o_res.ge = (i_entry >= i_key);
    end

endmodule

/* rtl/core/ost_cfg.sv */
// APB configuration register holding the list capacity.
module ost_cfg
    import ost_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [6:0]  o_capacity
);

    logic [6:0] r_capacity;
    logic       wr_en;

    assign wr_en = psel && penable && pwrite && (paddr == REG_CAPACITY_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (wr_en) begin
            r_capacity <= pwdata[6:0];
        end
    end

    assign prdata     = (paddr == REG_CAPACITY_ADDR) ? 32'(r_capacity) : 32'd0;
    assign pready     = 1'b1;
    assign o_capacity = r_capacity;

endmodule

/* rtl/core/ost_seq.sv */
// Sequencer that scans, shifts and compacts the stored list one entry per cycle.
module ost_seq
    import ost_pkg::*;
#(
    parameter int DEPTH       = OST_DEPTH,
    parameter int VALUE_WIDTH = OST_VALUE_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2:0]               i_operation,
    input  logic [6:0]               i_position,
    input  logic [31:0]              i_item_value,
    input  logic [6:0]               i_capacity,
    output logic                     o_busy,
    output logic                     o_done,
    output t_status                  o_status,
    output logic [5:0]               o_result_index,
    output logic [6:0]               o_removed_count,
    output logic [31:0]              o_read_value,
    output logic [6:0]               o_list_size,
    output logic                     o_is_empty,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [VALUE_WIDTH-1:0]   o_wdata,
    output logic                     o_re,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  logic [VALUE_WIDTH-1:0]   i_rdata,
    output logic [VALUE_WIDTH-1:0]   o_key,
    input  t_cmp                     i_cmp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > 7) ? CW : 7) + 1;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    t_status              r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_w, n_w;
    logic [CW-1:0]        r_rmv, n_rmv;
    logic [CW-1:0]        r_paddr, n_paddr;
    logic [AW-1:0]        r_idx, n_idx;
    logic [31:0]          r_rd, n_rd;
    logic                 r_pend, n_pend;

    logic [XW-1:0]          pos_x;
    logic [XW-1:0]          cnt_x;
    logic                   full;
    logic                   last;
    logic [VALUE_WIDTH-1:0] key_in;

    assign pos_x  = XW'(i_position);
    assign cnt_x  = XW'(r_cnt);
    assign full   = (cnt_x >= XW'(i_capacity)) || (cnt_x >= XW'(DEPTH));
    assign last   = ((r_paddr + CW'(1)) == r_cnt);
    assign key_in = VALUE_WIDTH'(i_item_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
        r_val    <= n_val;
        r_i      <= n_i;
        r_w      <= n_w;
        r_rmv    <= n_rmv;
        r_paddr  <= n_paddr;
        r_idx    <= n_idx;
        r_rd     <= n_rd;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        n_val    = r_val;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_w      = r_w;
        n_rmv    = r_rmv;
        n_paddr  = r_paddr;
        n_idx    = r_idx;
        n_rd     = r_rd;
        n_pend   = 1'b0;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = r_val;
        o_re     = 1'b0;
        o_raddr  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op     = t_op'(i_operation);
                    n_val    = key_in;
                    n_status = STAT_OK;
                    n_idx    = '0;
                    n_rmv    = '0;
                    n_rd     = '0;
                    n_w      = '0;
                    n_i      = '0;
                    n_state  = ST_DONE;
                    unique case (t_op'(i_operation))
                        OP_INSERT_AT: begin
                            if (pos_x > cnt_x) begin
                                n_status = STAT_RANGE;
                            end else if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_i     = r_cnt;
                                n_idx   = AW'(i_position);
                                n_state = ST_SHIFT_UP;
                            end
                        end
                        OP_INSERT_SORTED: begin
                            if (full) begin
                                n_status = STAT_FULL;
                            end else if (r_cnt == '0) begin
                                n_i     = r_cnt;
                                n_state = ST_SHIFT_UP;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_ERASE_AT: begin
                            if (pos_x >= cnt_x) begin
                                n_status = STAT_RANGE;
                            end else begin
                                n_i     = CW'(pos_x + XW'(1));
                                n_state = ST_SHIFT_DN;
                            end
                        end
                        OP_REMOVE_ALL: begin
                            if (r_cnt != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_FIND: begin
                            if (r_cnt == '0) begin
                                n_status = STAT_NOT_FOUND;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_GET: begin
                            if (pos_x >= cnt_x) begin
                                n_status = STAT_RANGE;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = AW'(i_position);
                                n_state = ST_READ;
                            end
                        end
                        OP_SET: begin
                            if (pos_x >= cnt_x) begin
                                n_status = STAT_RANGE;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = AW'(i_position);
                                o_wdata = key_in;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_i < r_cnt) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_i);
                    n_paddr = r_i;
                    n_i     = r_i + CW'(1);
                    n_pend  = 1'b1;
                end
                if (r_pend) begin
                    unique case (r_op)
                        OP_INSERT_SORTED: begin
                            if (i_cmp.ge) begin
                                n_idx   = AW'(r_paddr);
                                n_i     = r_cnt;
                                n_pend  = 1'b0;
                                n_state = ST_SHIFT_UP;
                            end else if (last) begin
                                n_idx   = AW'(r_cnt);
                                n_i     = r_cnt;
                                n_pend  = 1'b0;
                                n_state = ST_SHIFT_UP;
                            end
                        end
                        OP_REMOVE_ALL: begin
                            if (i_cmp.eq) begin
                                n_rmv = r_rmv + CW'(1);
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = AW'(r_w);
                                o_wdata = i_rdata;
                                n_w     = r_w + CW'(1);
                            end
                            if (last) begin
                                n_cnt   = r_w + CW'(!i_cmp.eq);
                                n_pend  = 1'b0;
                                n_state = ST_DONE;
                            end
                        end
                        OP_FIND: begin
                            if (i_cmp.eq) begin
                                n_idx   = AW'(r_paddr);
                                n_pend  = 1'b0;
                                n_state = ST_DONE;
                            end else if (last) begin
                                n_status = STAT_NOT_FOUND;
                                n_pend   = 1'b0;
                                n_state  = ST_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_paddr + CW'(1));
                    o_wdata = i_rdata;
                end
                if (r_i > CW'(r_idx)) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_i - CW'(1));
                    n_paddr = r_i - CW'(1);
                    n_i     = r_i - CW'(1);
                    n_pend  = 1'b1;
                end else if (!r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_idx;
                    o_wdata = r_val;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT_DN: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_paddr - CW'(1));
                    o_wdata = i_rdata;
                end
                if (r_i < r_cnt) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_i);
                    n_paddr = r_i;
                    n_i     = r_i + CW'(1);
                    n_pend  = 1'b1;
                end else if (!r_pend) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_rd    = 32'(i_rdata);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_done          = (r_state == ST_DONE);
    assign o_status        = r_status;
    assign o_result_index  = 6'(r_idx);
    assign o_removed_count = 7'(r_rmv);
    assign o_read_value    = r_rd;
    assign o_list_size     = 7'(r_cnt);
    assign o_is_empty      = (r_cnt == '0);
    assign o_key           = r_val;

endmodule

/* test/tb.sv */
// Self-checking testbench for the ordered sequence table core with a list scoreboard.
`timescale 1ns / 100ps

module tb;
    import ost_pkg::*;

    localparam logic [2:0] OP_UNUSED      = 3'd7;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         ITEMS_PER_PHASE = 64;

    typedef struct packed {
        t_status     status;
        logic [5:0]  slot_index;
        logic [6:0]  removed;
        logic [31:0] read_data;
        logic [6:0]  size_after;
        logic        is_empty;
    } t_reply;

    class list_scoreboard;
        logic [31:0] entries[$];
        logic [6:0]  capacity;
        t_reply      expected_replies[$];
        int          fails;

        function new();
            capacity = CAP_RESET;
            fails    = 0;
        endfunction

        function void set_capacity(logic [6:0] cap);
            capacity = cap;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_command(logic [2:0] op, logic [6:0] pos, logic [31:0] value);
            t_reply      r;
            int          n;
            int          p;
            int          limit;
            logic [31:0] kept[$];

            r     = '0;
            r.status = STAT_OK;
            n     = entries.size();
            p     = int'(pos);
            limit = (int'(capacity) < OST_DEPTH) ? int'(capacity) : OST_DEPTH;
            case (op)
                OP_INSERT_AT: begin
                    if (p > n) begin
                        r.status = STAT_RANGE;
                    end else if (n >= limit) begin
                        r.status = STAT_FULL;
                    end else begin
                        entries.insert(p, value);
                        r.slot_index = p[5:0];
                    end
                end
                OP_INSERT_SORTED: begin
                    if (n >= limit) begin
                        r.status = STAT_FULL;
                    end else begin
                        p = n;
                        for (int i = 0; i < n; i++) begin
                            if (entries[i] >= value) begin
                                p = i;
                                break;
                            end
                        end
                        entries.insert(p, value);
                        r.slot_index = p[5:0];
                    end
                end
                OP_ERASE_AT: begin
                    if (p >= n) r.status = STAT_RANGE;
                    else entries.delete(p);
                end
                OP_REMOVE_ALL: begin
                    foreach (entries[i]) begin
                        if (entries[i] == value) r.removed++;
                        else kept.push_back(entries[i]);
                    end
                    entries = kept;
                end
                OP_FIND: begin
                    r.status = STAT_NOT_FOUND;
                    for (int i = 0; i < n; i++) begin
                        if (entries[i] == value) begin
                            r.status     = STAT_OK;
                            r.slot_index = i[5:0];
                            break;
                        end
                    end
                end
                OP_GET: begin
                    if (p >= n) r.status = STAT_RANGE;
                    else r.read_data = entries[p];
                end
                OP_SET: begin
                    if (p >= n) r.status = STAT_RANGE;
                    else entries[p] = value;
                end
                default: begin
                end
            endcase
            r.size_after = 7'(entries.size());
            r.is_empty   = (entries.size() == 0);
            expected_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_reply(t_reply got);
            t_reply want;

            if (expected_replies.size() == 0) begin
                $error("result beat with no command outstanding");
                fails++;
                return;
            end
            want = expected_replies.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("result_index", 32'(want.slot_index), 32'(got.slot_index));
            compare_field("removed_count", 32'(want.removed), 32'(got.removed));
            compare_field("read_value", want.read_data, got.read_data);
            compare_field("list_size", 32'(want.size_after), 32'(got.size_after));
            compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [2:0]  i_operation;
    logic [6:0]  i_position;
    logic [31:0] i_item_value;
    logic        o_done;
    logic [1:0]  o_status;
    logic [5:0]  o_result_index;
    logic [6:0]  o_removed_count;
    logic [31:0] o_read_value;
    logic [6:0]  o_list_size;
    logic        o_is_empty;

    list_scoreboard sb;
    int             idle_cycles;
    logic [6:0]     cap_plan [9] = '{7'd64, 7'd0, 7'd1, 7'd2, 7'd9, 7'd127, 7'd40, 7'd3, 7'd64};

    ordered_sequence_table_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_position     (i_position),
        .i_item_value   (i_item_value),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_index (o_result_index),
        .o_removed_count(o_removed_count),
        .o_read_value   (o_read_value),
        .o_list_size    (o_list_size),
        .o_is_empty     (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_reply('{t_status'(o_status), o_result_index, o_removed_count,
                             o_read_value, o_list_size, o_is_empty});
        end
        if (i_rst_n && start && !busy) begin
            sb.note_command(i_operation, i_position, i_item_value);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [6:0] pos,
                             input logic [31:0] value);
        start        = 1'b1;
        i_operation  = op;
        i_position   = pos;
        i_item_value = value;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [6:0] cap);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_CAPACITY_ADDR;
        pwdata  = {25'd0, cap};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_capacity(cap);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [2:0] pick_op();
        int r;

        r = $urandom_range(0, 99);
        if (r < 25) return OP_INSERT_AT;
        if (r < 45) return OP_INSERT_SORTED;
        if (r < 55) return OP_ERASE_AT;
        if (r < 63) return OP_REMOVE_ALL;
        if (r < 75) return OP_FIND;
        if (r < 87) return OP_GET;
        if (r < 97) return OP_SET;
        return OP_UNUSED;
    endfunction

    function automatic logic [6:0] pick_position();
        int r;
        int n;

        r = $urandom_range(0, 99);
        n = sb.entries.size();
        if (r < 75) return 7'($urandom_range(0, n));
        if (r < 85) return (n == 0) ? 7'd0 : 7'(n - 1);
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [31:0] pick_value();
        int r;

        r = $urandom_range(0, 99);
        if (r < 35 && sb.entries.size() != 0)
            return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
        if (r < 65) return $urandom_range(0, 7);
        if (r < 72) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    initial begin
        bit quiet;

        sb           = new();
        idle_cycles  = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        i_operation  = OP_GET;
        i_position   = '0;
        i_item_value = '0;
        quiet        = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_item(OP_GET, 7'd0, 32'd0);
        send_item(OP_ERASE_AT, 7'd0, 32'd0);
        send_item(OP_FIND, 7'd0, 32'd5);
        send_item(OP_REMOVE_ALL, 7'd0, 32'd5);
        send_item(OP_INSERT_AT, 7'd1, 32'd1);
        send_item(OP_INSERT_AT, 7'd0, 32'hFFFF_FFFF);
        send_item(OP_INSERT_SORTED, 7'd0, 32'd0);
        send_item(OP_INSERT_SORTED, 7'd0, 32'h8000_0000);
        send_item(OP_INSERT_SORTED, 7'd0, 32'hFFFF_FFFF);
        send_item(OP_INSERT_AT, 7'd4, 32'd7);
        send_item(OP_FIND, 7'd0, 32'hFFFF_FFFF);
        send_item(OP_REMOVE_ALL, 7'd0, 32'hFFFF_FFFF);
        send_item(OP_SET, 7'd0, 32'd7);
        send_item(OP_SET, 7'd64, 32'd3);
        send_item(OP_GET, 7'd1, 32'd0);
        send_item(OP_REMOVE_ALL, 7'd0, 32'd7);
        send_item(OP_UNUSED, 7'd0, 32'd8);
        send_item(OP_ERASE_AT, 7'd0, 32'd0);
        send_item(OP_INSERT_SORTED, 7'd0, 32'd30);
        send_item(OP_INSERT_SORTED, 7'd0, 32'd10);
        send_item(OP_INSERT_SORTED, 7'd0, 32'd20);
        drain_pipeline();
        write_capacity(7'd2);
        send_item(OP_INSERT_SORTED, 7'd0, 32'd15);
        send_item(OP_INSERT_AT, 7'd9, 32'd15);
        send_item(OP_INSERT_AT, 7'd0, 32'd15);
        send_item(OP_ERASE_AT, 7'd2, 32'd0);
        send_item(OP_ERASE_AT, 7'd0, 32'd0);
        send_item(OP_INSERT_SORTED, 7'd0, 32'd25);

        foreach (cap_plan[ph]) begin
            drain_pipeline();
            write_capacity(cap_plan[ph]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
                if (ph != $size(cap_plan) - 1) begin
                    if (!quiet && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 5));
                    if ($urandom_range(0, 49) == 0) drain_pipeline();
                end
                send_item(pick_op(), pick_position(), pick_value());
            end
        end

        drain_pipeline();
        repeat (2 * OST_DEPTH + 8) @(negedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
